@@ src/tss_pkg.sv @@
`default_nettype none

package tss_pkg;

  localparam int DATA_W = 32;
  localparam int KEEP_W = 6;
  localparam int RANK_W = 5;
  localparam int PADDR_W = 3;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd32;

  // Kind codes of an input transaction
  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0]        id;
    logic signed [DATA_W-1:0] fit;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_WNEW  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

endpackage

`default_nettype wire

@@ src/tss_mem.sv @@
`default_nettype none

module tss_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire tss_pkg::entry_t wdata_i,
  input  wire logic            re_i,
  input  wire logic [AW-1:0]   raddr_i,
  output tss_pkg::entry_t      rdata_o
);
  import tss_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/tss_cfg.sv @@
`default_nettype none

module tss_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tss_pkg::PADDR_W-1:0] paddr,
  input  wire logic [tss_pkg::DATA_W-1:0]  pwdata,
  output logic [tss_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  output logic [tss_pkg::KEEP_W-1:0]       keep_o
);
  import tss_pkg::*;

  logic              keep_hit;
  logic              keep_we;
  logic [KEEP_W-1:0] keep_q;
  logic [KEEP_W-1:0] keep_d;

  // keep_count is the only register, answered at every address whose top bit is clear
  assign keep_hit = (paddr[PADDR_W-1] == 1'b0);
  assign keep_we  = psel && penable && pwrite && keep_hit;
  assign keep_d   = keep_we ? pwdata[KEEP_W-1:0] : keep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KEEP_RESET;
    end else begin
      keep_q <= keep_d;
    end
  end

  assign prdata = keep_hit ? DATA_W'(keep_q) : '0;
  assign pready = 1'b1;
  assign keep_o = keep_q;

endmodule

`default_nettype wire

@@ src/truncation_survivor_select.sv @@
// Keeps the best keep_count candidates of a generation in a rank table held in
// one synchronous RAM, sorted by falling fitness; ties go behind stored equals.
// An offer walks the table from its tail, one entry per cycle through the RAM's
// single read and write port, shifting worse entries down by one slot while busy
// stays high. A flush reads the table in rank order, one entry per cycle, and
// strobes out_valid_o once per entry on consecutive cycles; each result is
// registered at the RAM read port and again at the outputs. busy stays high
// while the entries are read. The last result carries out_last_o and the wrapped
// sum of fitness. A flush of an empty table sends nothing.
// Results cannot be held off: sample them in the cycle out_valid_o is high.
`default_nettype none

module truncation_survivor_select #(
  parameter int MAX_KEEP = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tss_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [tss_pkg::DATA_W-1:0]        pwdata,
  output logic [tss_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              kind_i,
  input  wire logic [tss_pkg::DATA_W-1:0]        cand_id_i,
  input  wire logic signed [tss_pkg::DATA_W-1:0] cand_fitness_i,
  output logic                                   out_valid_o,
  output logic [tss_pkg::DATA_W-1:0]             out_id_o,
  output logic signed [tss_pkg::DATA_W-1:0]      out_fitness_o,
  output logic [tss_pkg::RANK_W-1:0]             out_rank_o,
  output logic                                   out_last_o,
  output logic signed [tss_pkg::DATA_W-1:0]      total_fitness_o
);
  import tss_pkg::*;

  localparam int AW = $clog2(MAX_KEEP);
  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int KW = (CW > KEEP_W) ? CW : KEEP_W;

  logic [KEEP_W-1:0] keep_reg;
  logic [KW-1:0]     keep_ext;
  logic [CW-1:0]     keep_eff;
  logic [CW-1:0]     fill_eff;
  logic              not_full;

  state_e state_q, state_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [CW-1:0]     slot_q, slot_d;
  logic [CW-1:0]     slot_m1;
  logic [CW-1:0]     slot_m2;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     cnt_p1;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic [DATA_W-1:0] cand_id_q;
  logic signed [DATA_W-1:0] cand_fit_q;
  logic              take;

  logic              rv_q, rv_d;
  logic              rlast_q, rlast_d;
  logic [RANK_W-1:0] rrank_q, rrank_d;
  logic signed [DATA_W-1:0] sum_q, sum_d;

  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t      mem_wdata;
  logic        mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t      mem_rdata;
  entry_t      new_entry;
  logic        old_ge;

  logic              oval_q;
  logic              olast_q;
  logic [RANK_W-1:0] orank_q;
  logic [DATA_W-1:0] oid_q;
  logic signed [DATA_W-1:0] ofit_q;
  logic signed [DATA_W-1:0] otot_q;

  tss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .keep_o  (keep_reg)
  );

  tss_mem #(
    .DEPTH (MAX_KEEP),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Clamp keep_count to 1..MAX_KEEP, and the fill count to the current limit
  always_comb begin
    keep_ext = KW'(keep_reg);
    if (keep_ext == '0) begin
      keep_eff = CW'(1);
    end else if (keep_ext > KW'(MAX_KEEP)) begin
      keep_eff = CW'(MAX_KEEP);
    end else begin
      keep_eff = keep_ext[CW-1:0];
    end
  end

  assign fill_eff  = (fill_q > keep_eff) ? keep_eff : fill_q;
  assign not_full  = (fill_eff < keep_eff);
  assign take      = start && !busy;
  assign slot_m1   = slot_q - CW'(1);
  assign slot_m2   = slot_q - CW'(2);
  assign cnt_p1    = cnt_q + CW'(1);
  assign new_entry = '{id: cand_id_q, fit: cand_fit_q};
  assign old_ge    = (mem_rdata.fit >= cand_fit_q);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_eff;
    slot_d    = slot_q;
    cnt_d     = cnt_q;
    rank_d    = rank_q;
    rv_d      = 1'b0;
    rlast_d   = rlast_q;
    rrank_d   = rrank_q;
    mem_we    = 1'b0;
    mem_waddr = slot_q[AW-1:0];
    mem_wdata = new_entry;
    mem_re    = 1'b0;
    mem_raddr = slot_m1[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (take) begin
          if (kind_i == KIND_OFFER) begin
            // Start at the first free slot, or one past the tail when full
            slot_d    = not_full ? fill_eff : keep_eff;
            mem_raddr = AW'(slot_d - CW'(1));
            if (slot_d == '0) begin
              state_d = S_WNEW;
            end else begin
              mem_re  = 1'b1;
              state_d = S_CMP;
            end
          end else if (fill_eff != '0) begin
            cnt_d   = '0;
            rank_d  = '0;
            state_d = S_FLUSH;
          end
        end
      end

      S_CMP: begin
        if (old_ge) begin
          // Candidate lands in the current slot; beyond the limit it is dropped
          if (slot_q != keep_eff) begin
            mem_we = 1'b1;
            if (not_full) begin
              fill_d = fill_eff + CW'(1);
            end
          end
          state_d = S_IDLE;
        end else begin
          // Shift the worse entry down; past the limit it falls off
          mem_we    = (slot_q != keep_eff);
          mem_wdata = mem_rdata;
          slot_d    = slot_m1;
          mem_raddr = slot_m2[AW-1:0];
          if (slot_m1 == '0) begin
            state_d = S_WNEW;
          end else begin
            mem_re = 1'b1;
          end
        end
      end

      S_WNEW: begin
        mem_we = 1'b1;
        if (not_full) begin
          fill_d = fill_eff + CW'(1);
        end
        state_d = S_IDLE;
      end

      S_FLUSH: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_q[AW-1:0];
        rv_d      = 1'b1;
        rrank_d   = rank_q;
        rlast_d   = (cnt_p1 == fill_eff);
        cnt_d     = cnt_p1;
        rank_d    = rank_q + RANK_W'(1);
        if (cnt_p1 == fill_eff) begin
          fill_d  = '0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Running sum restarts with each flush transaction
  always_comb begin
    sum_d = sum_q;
    if (state_q == S_IDLE) begin
      sum_d = '0;
    end else if (rv_q) begin
      sum_d = sum_q + mem_rdata.fit;
    end
    if (rv_q) begin
      sum_d = sum_q + mem_rdata.fit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      rv_q    <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rv_q    <= rv_d;
      oval_q  <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    cnt_q   <= cnt_d;
    rank_q  <= rank_d;
    rlast_q <= rlast_d;
    rrank_q <= rrank_d;
    if (take && state_q == S_IDLE) begin
      cand_id_q  <= cand_id_i;
      cand_fit_q <= cand_fitness_i;
    end
    if (take && kind_i == KIND_FLUSH) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
    if (rv_q) begin
      oid_q   <= mem_rdata.id;
      ofit_q  <= mem_rdata.fit;
      orank_q <= rrank_q;
      olast_q <= rlast_q;
      otot_q  <= rlast_q ? sum_d : '0;
    end
  end

  assign busy            = (state_q != S_IDLE) || rv_q;
  assign out_valid_o     = oval_q;
  assign out_id_o        = oid_q;
  assign out_fitness_o   = ofit_q;
  assign out_rank_o      = orank_q;
  assign out_last_o      = oval_q && olast_q;
  assign total_fitness_o = otot_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MAX_KEEP))
    else $error("fill count beyond table depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same entry in one cycle");

  a_cmp_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (slot_q != '0))
    else $error("compare step with no entry above the slot");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> (fill_q == '0))
    else $error("table not emptied after last flush result");

  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_last_o) |=> out_valid_o)
    else $error("flush results not back to back");

endmodule

`default_nettype wire
